/* rtl/lrs_pkg.sv */
// Shared constants, types and register codes for the line rasterizer stepper.
`timescale 1ns / 1ps

package lrs_pkg;

    localparam int COORD_BITS    = 14;
    localparam int DELTA_BITS    = COORD_BITS + 1;
    localparam int ERR_BITS      = COORD_BITS + 3;
    localparam int DIM_BITS      = 14;
    localparam int COLOR_BITS    = 8;
    localparam int CMP_BITS      = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = (DIM_BITS > COLOR_BITS) ? DIM_BITS : COLOR_BITS;
    localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_USED_BITS = 2 * COORD_BITS + 3 * COLOR_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_COLOR_RED    = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_COLOR_GREEN  = CFG_IDX_BITS'(3);
    localparam logic [CFG_IDX_BITS-1:0] REG_COLOR_BLUE   = CFG_IDX_BITS'(4);

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [DELTA_BITS-1:0]        t_delta;
    typedef logic signed [ERR_BITS-1:0]   t_err;

    // Registered input request with the endpoint deltas already resolved.
    typedef struct packed {
        logic   action;
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
        t_delta abs_dx;
        t_delta abs_dy;
        logic   x_neg;
        logic   y_neg;
    } t_item;

    typedef struct packed {
        logic                  y_neg;
        logic                  x_neg;
        logic                  y_major;
    } t_flags;

    typedef struct packed {
        logic [DIM_BITS-1:0]   width;
        logic [DIM_BITS-1:0]   height;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } t_cfg;

endpackage

/* rtl/line_rasterizer_stepper.sv */
// Top level of the line rasterizer stepper.
`timescale 1ns / 1ps

// Line rasterizer stepper: a start request (tuser low) loads both endpoints and
// returns the first endpoint as a pixel; each step request (tuser high) returns
// the next pixel of the line along the major axis, using the usual integer
// error term. The pixel equal to the second endpoint comes out with tlast set,
// after which step requests are consumed without producing a result until the
// next start. A start always restarts, even in the middle of a line. Equal
// endpoints give one pixel with tlast set. Each result carries an in-bounds flag
// on tuser (0 <= x < image width and 0 <= y < image height) and the current
// color registers, so a frame buffer writer can drop off-screen pixels.
// Throughput is one request per clock while the results are taken: the endpoint
// deltas are formed on the way into the input register, and the add, compare
// and increment of the line state run combinationally between the input
// register and the output register, written back in time for the very next
// request. A request is held in the input register and its result in the
// output register until taken. A result waits in the output
// register while the input register keeps accepting, so input stalls only when
// both registers are full. Configuration writes are always accepted and take
// effect at the next request that reaches the stepping logic; write them only
// while no request is in flight.
module line_rasterizer_stepper
    import lrs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Requests
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,  // start_x, start_y, end_x, end_y
    input  logic                     s_tuser,  // action
    // Results
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,  // pixel_x, pixel_y, red, green, blue, zero pad
    output logic                     m_tuser,  // in_bounds
    output logic                     m_tlast,  // last_pixel
    // Configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg  cfg;
    t_item item;
    logic  item_valid;
    logic  take;

    lrs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // The input register; the stepping logic frees it in the cycle it fires.
    lrs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .i_take   (take),
        .o_valid  (item_valid),
        .o_item   (item)
    );

    // Line state, the per-pixel step and the result register.
    lrs_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (item_valid),
        .i_item   (item),
        .i_cfg    (cfg),
        .o_take   (take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/lrs_cfg_regs.sv */
// Configuration register file: image size and line color.
`timescale 1ns / 1ps

module lrs_cfg_regs
    import lrs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= WIDTH_RESET;
            r_cfg.height <= HEIGHT_RESET;
            r_cfg.red    <= '0;
            r_cfg.green  <= '0;
            r_cfg.blue   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_cfg.width  <= i_cfg_data[DIM_BITS-1:0];
                REG_IMAGE_HEIGHT: r_cfg.height <= i_cfg_data[DIM_BITS-1:0];
                REG_COLOR_RED:    r_cfg.red    <= i_cfg_data[COLOR_BITS-1:0];
                REG_COLOR_GREEN:  r_cfg.green  <= i_cfg_data[COLOR_BITS-1:0];
                REG_COLOR_BLUE:   r_cfg.blue   <= i_cfg_data[COLOR_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

/* rtl/lrs_front.sv */
// Input register: captures a request and resolves the absolute endpoint deltas.
`timescale 1ns / 1ps

module lrs_front
    import lrs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_DATA_BITS-1:0] s_tdata,
    input  logic                    s_tuser,
    input  logic                    i_take,
    output logic                    o_valid,
    output t_item                   o_item
);

    logic   r_valid;
    t_item  r_item;
    t_item  n_item;
    t_delta dx;
    t_delta dy;

    assign s_tready = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_item   = r_item;

    always_comb begin
        n_item.action = s_tuser;
        n_item.x0     = s_tdata[COORD_BITS-1:0];
        n_item.y0     = s_tdata[2*COORD_BITS-1:COORD_BITS];
        n_item.x1     = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
        n_item.y1     = s_tdata[4*COORD_BITS-1:3*COORD_BITS];
        dx = {n_item.x1[COORD_BITS-1], n_item.x1} - {n_item.x0[COORD_BITS-1], n_item.x0};
        dy = {n_item.y1[COORD_BITS-1], n_item.y1} - {n_item.y0[COORD_BITS-1], n_item.y0};
        n_item.x_neg  = dx[DELTA_BITS-1];
        n_item.y_neg  = dy[DELTA_BITS-1];
        n_item.abs_dx = n_item.x_neg ? (~dx + t_delta'(1)) : dx;
        n_item.abs_dy = n_item.y_neg ? (~dy + t_delta'(1)) : dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_tready) begin
            r_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_item <= n_item;
        end
    end

endmodule

/* rtl/lrs_core.sv */
// Line state and combinational stepping logic feeding the result register.
`timescale 1ns / 1ps

module lrs_core
    import lrs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  t_item                    i_item,
    input  t_cfg                     i_cfg,
    output logic                     o_take,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    output logic                     m_tuser,
    output logic                     m_tlast
);

    // Line state
    t_coord r_cur_x;
    t_coord r_cur_y;
    t_coord r_tgt_x;
    t_coord r_tgt_y;
    t_delta r_dminor;
    t_err   r_ddiff;
    t_err   r_err;
    t_flags r_flags;
    logic   r_active;

    // Result register
    logic                     r_out_valid;
    logic [OUT_DATA_BITS-1:0] r_out_data;
    logic                     r_out_inb;
    logic                     r_out_last;

    logic                     fire;
    logic                     is_start;
    logic                     emit;
    logic signed [DELTA_BITS:0] major_cmp;
    logic                     start_ymaj;
    t_delta                   start_dminor;
    t_err                     start_ddiff;
    t_err                     err_add;
    t_err                     err_sub;
    logic                     minor_moves;
    t_err                     step_err;
    t_coord                   sx;
    t_coord                   sy;
    logic                     move_x;
    logic                     move_y;
    t_coord                   step_x;
    t_coord                   step_y;
    t_coord                   px;
    t_coord                   py;
    t_coord                   tx;
    t_coord                   ty;
    logic                     last;
    logic                     inb;

    assign fire     = i_valid && (!r_out_valid || m_tready);
    assign o_take   = fire;
    assign is_start = (i_item.action == ACT_START);
    assign emit     = is_start || r_active;

    always_comb begin
        // Start: y is major only when its delta is strictly larger.
        major_cmp    = $signed({1'b0, i_item.abs_dx}) - $signed({1'b0, i_item.abs_dy});
        start_ymaj   = major_cmp[DELTA_BITS];
        start_dminor = start_ymaj ? i_item.abs_dx : i_item.abs_dy;
        // delta_minor - delta_major, never positive
        start_ddiff  = start_ymaj ? ERR_BITS'(major_cmp) : ERR_BITS'(-major_cmp);

        // Step: both candidate error values are formed in parallel.
        err_add     = r_err + t_err'({1'b0, r_dminor});
        err_sub     = r_err + r_ddiff;
        minor_moves = !err_add[ERR_BITS-1] && (err_add != '0);
        step_err    = minor_moves ? err_sub : err_add;

        sx     = r_flags.x_neg ? t_coord'(-1) : t_coord'(1);
        sy     = r_flags.y_neg ? t_coord'(-1) : t_coord'(1);
        move_x = r_flags.y_major ? minor_moves : 1'b1;
        move_y = r_flags.y_major ? 1'b1 : minor_moves;
        step_x = move_x ? (r_cur_x + sx) : r_cur_x;
        step_y = move_y ? (r_cur_y + sy) : r_cur_y;

        if (is_start) begin
            px = i_item.x0;
            py = i_item.y0;
            tx = i_item.x1;
            ty = i_item.y1;
        end else begin
            px = step_x;
            py = step_y;
            tx = r_tgt_x;
            ty = r_tgt_y;
        end

        last = (px == tx) && (py == ty);
        inb  = !px[COORD_BITS-1] && !py[COORD_BITS-1]
            && (CMP_BITS'($unsigned(px)) < CMP_BITS'(i_cfg.width))
            && (CMP_BITS'($unsigned(py)) < CMP_BITS'(i_cfg.height));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (fire && emit) begin
            r_active <= !last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            if (is_start) begin
                r_cur_x         <= i_item.x0;
                r_cur_y         <= i_item.y0;
                r_tgt_x         <= i_item.x1;
                r_tgt_y         <= i_item.y1;
                r_dminor        <= start_dminor;
                r_ddiff         <= start_ddiff;
                r_err           <= '0;
                r_flags.y_major <= start_ymaj;
                r_flags.x_neg   <= i_item.x_neg;
                r_flags.y_neg   <= i_item.y_neg;
            end else if (r_active) begin
                r_cur_x <= step_x;
                r_cur_y <= step_y;
                r_err   <= step_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= emit;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_out_data <= {(OUT_DATA_BITS - OUT_USED_BITS)'(0),
                           i_cfg.blue, i_cfg.green, i_cfg.red, py, px};
            r_out_inb  <= inb;
            r_out_last <= last;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_inb;
    assign m_tlast  = r_out_last;

endmodule

/* rtl/lrs_checker.sv */
// Port-level checks for the line rasterizer stepper, bound to the top level.
`timescale 1ns / 1ps

module lrs_checker
    import lrs_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OUT_DATA_BITS-1:0] m_tdata,
    input logic                     m_tuser,
    input logic                     m_tlast
);

    // A held result must not change under backpressure.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast)))
        else $error("result changed or dropped while stalled");

    // The request side stalls only when a result is stuck in the output register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("request side stalled without output backpressure");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid right after reset");

    // The zero padding of the result data stays zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[OUT_DATA_BITS-1:OUT_USED_BITS] == '0))
        else $error("result padding bits not zero");

endmodule

bind line_rasterizer_stepper lrs_checker u_lrs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* bench/line_pixel_checker.sv */
// Checker that predicts every pixel of the line rasterizer stepper and compares results.
`timescale 1ns / 1ps

module line_pixel_checker
    import lrs_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_req_valid,
    input  logic                     i_req_ready,
    input  logic [IN_DATA_BITS-1:0]  i_req_data,
    input  logic                     i_req_action,
    input  logic                     i_pix_valid,
    input  logic                     i_pix_ready,
    input  logic [OUT_DATA_BITS-1:0] i_pix_data,
    input  logic                     i_pix_inb,
    input  logic                     i_pix_last,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_checked
);

    localparam int Y_LSB     = COORD_BITS;
    localparam int RED_LSB   = 2 * COORD_BITS;
    localparam int GREEN_LSB = RED_LSB + COLOR_BITS;
    localparam int BLUE_LSB  = GREEN_LSB + COLOR_BITS;

    typedef struct {
        t_coord                x;
        t_coord                y;
        logic                  inb;
        logic                  last;
        logic [COLOR_BITS-1:0] red;
        logic [COLOR_BITS-1:0] green;
        logic [COLOR_BITS-1:0] blue;
    } t_pixel;

    t_cfg   regs;
    t_coord cur_x;
    t_coord cur_y;
    t_coord tgt_x;
    t_coord tgt_y;
    t_delta d_major;
    t_delta d_minor;
    t_err   err;
    t_flags dir;
    logic   drawing;
    t_pixel pixel_q[$];

    task automatic report_mismatch(input string msg);
        o_errors++;
        $display("checker: pixel %0d: %s", o_checked, msg);
    endtask

    function automatic t_coord nudge(input t_coord v, input logic down);
        return down ? t_coord'(v - 1'b1) : t_coord'(v + 1'b1);
    endfunction

    // Queue the pixel at the current position and close the line when it is the end point.
    task automatic queue_pixel();
        t_pixel p;
        int     px;
        int     py;
        int     w;
        int     h;
        px = cur_x;
        py = cur_y;
        w  = int'(regs.width);
        h  = int'(regs.height);
        p.x     = cur_x;
        p.y     = cur_y;
        p.inb   = (px >= 0) && (py >= 0) && (px < w) && (py < h);
        p.last  = (cur_x == tgt_x) && (cur_y == tgt_y);
        p.red   = regs.red;
        p.green = regs.green;
        p.blue  = regs.blue;
        drawing = !p.last;
        pixel_q.push_back(p);
    endtask

    task automatic predict_request(input logic act, input logic [IN_DATA_BITS-1:0] data);
        t_coord c;
        int     x0;
        int     y0;
        int     x1;
        int     y1;
        int     dx;
        int     dy;
        int     e;
        logic   minor_moves;
        if (act == ACT_START) begin
            c  = data[0 +: COORD_BITS];
            x0 = c;
            c  = data[COORD_BITS +: COORD_BITS];
            y0 = c;
            c  = data[2*COORD_BITS +: COORD_BITS];
            x1 = c;
            c  = data[3*COORD_BITS +: COORD_BITS];
            y1 = c;
            dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
            dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
            // Ties go to the x axis.
            dir.y_major = dy > dx;
            dir.x_neg   = x1 < x0;
            dir.y_neg   = y1 < y0;
            d_major = t_delta'(dir.y_major ? dy : dx);
            d_minor = t_delta'(dir.y_major ? dx : dy);
            cur_x = t_coord'(x0);
            cur_y = t_coord'(y0);
            tgt_x = t_coord'(x1);
            tgt_y = t_coord'(y1);
            err   = '0;
            queue_pixel();
        end else if (drawing) begin
            e = err;
            e = e + int'(d_minor);
            minor_moves = e > 0;
            if (minor_moves) begin
                e = e - int'(d_major);
            end
            err = t_err'(e);
            if (dir.y_major) begin
                cur_y = nudge(cur_y, dir.y_neg);
                if (minor_moves) begin
                    cur_x = nudge(cur_x, dir.x_neg);
                end
            end else begin
                cur_x = nudge(cur_x, dir.x_neg);
                if (minor_moves) begin
                    cur_y = nudge(cur_y, dir.y_neg);
                end
            end
            queue_pixel();
        end
        // A step with no line in progress is dropped without a result.
    endtask

    task automatic check_pixel();
        t_pixel                p;
        t_coord                got_x;
        t_coord                got_y;
        logic [COLOR_BITS-1:0] got_r;
        logic [COLOR_BITS-1:0] got_g;
        logic [COLOR_BITS-1:0] got_b;
        got_x = i_pix_data[0 +: COORD_BITS];
        got_y = i_pix_data[Y_LSB +: COORD_BITS];
        got_r = i_pix_data[RED_LSB +: COLOR_BITS];
        got_g = i_pix_data[GREEN_LSB +: COLOR_BITS];
        got_b = i_pix_data[BLUE_LSB +: COLOR_BITS];
        if (pixel_q.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel (%0d, %0d)", got_x, got_y));
        end else begin
            p = pixel_q.pop_front();
            if (got_x !== p.x)
                report_mismatch($sformatf("pixel_x %0d, expected %0d", got_x, p.x));
            if (got_y !== p.y)
                report_mismatch($sformatf("pixel_y %0d, expected %0d", got_y, p.y));
            if (i_pix_inb !== p.inb)
                report_mismatch($sformatf("in_bounds %b, expected %b", i_pix_inb, p.inb));
            if (i_pix_last !== p.last)
                report_mismatch($sformatf("last_pixel %b, expected %b", i_pix_last, p.last));
            if (got_r !== p.red)
                report_mismatch($sformatf("red %0d, expected %0d", got_r, p.red));
            if (got_g !== p.green)
                report_mismatch($sformatf("green %0d, expected %0d", got_g, p.green));
            if (got_b !== p.blue)
                report_mismatch($sformatf("blue %0d, expected %0d", got_b, p.blue));
            o_checked++;
        end
    endtask

    // Registers change only while the block is idle, so they are applied first;
    // results are matched before new requests are queued at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.width  = WIDTH_RESET;
            regs.height = HEIGHT_RESET;
            regs.red    = '0;
            regs.green  = '0;
            regs.blue   = '0;
            cur_x   = '0;
            cur_y   = '0;
            tgt_x   = '0;
            tgt_y   = '0;
            d_major = '0;
            d_minor = '0;
            err     = '0;
            dir     = '0;
            drawing = 1'b0;
            pixel_q.delete();
            o_errors  = 0;
            o_checked = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH: begin
                        regs.width = i_cfg_data[DIM_BITS-1:0];
                    end
                    REG_IMAGE_HEIGHT: begin
                        regs.height = i_cfg_data[DIM_BITS-1:0];
                    end
                    REG_COLOR_RED: begin
                        regs.red = i_cfg_data[COLOR_BITS-1:0];
                    end
                    REG_COLOR_GREEN: begin
                        regs.green = i_cfg_data[COLOR_BITS-1:0];
                    end
                    REG_COLOR_BLUE: begin
                        regs.blue = i_cfg_data[COLOR_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_pix_valid && i_pix_ready) begin
                check_pixel();
            end
            if (i_req_valid && i_req_ready) begin
                predict_request(i_req_action, i_req_data);
            end
        end
        o_pending = pixel_q.size();
    end

endmodule

/* bench/testbench.sv */
// Top of the line rasterizer stepper bench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import lrs_pkg::*;

    // The run stops here even if the block hangs; the limit covers every request
    // waiting out the longest gap and stall on both sides many times over.
    localparam int LIMIT     = 200000;
    localparam int ITEM_GOAL = 700;
    localparam int NO_CAP    = 1 << 30;
    localparam int COORD_LO  = -(1 << (COORD_BITS - 1));
    localparam int COORD_HI  = (1 << (COORD_BITS - 1)) - 1;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;   // start_x, start_y, end_x, end_y
    logic                     s_tuser;   // action
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;   // pixel_x, pixel_y, red, green, blue, zero pad
    logic                     m_tuser;   // in_bounds
    logic                     m_tlast;   // last_pixel
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    int errors;
    int pending;
    int checked;
    int cycle_count;
    int hold_cycles;
    bit tx_steady;
    bit rx_steady;

    // Bookkeeping for shaping the stimulus only; the checker does all prediction.
    int starts;
    int steps;
    int useful;
    int settings;
    int line_left;
    int img_w;
    int img_h;

    line_rasterizer_stepper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    line_pixel_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_tvalid),
        .i_req_ready  (s_tready),
        .i_req_data   (s_tdata),
        .i_req_action (s_tuser),
        .i_pix_valid  (m_tvalid),
        .i_pix_ready  (m_tready),
        .i_pix_data   (m_tdata),
        .i_pix_inb    (m_tuser),
        .i_pix_last   (m_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels still expected", cycle_count, pending);
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Result side. A requested hold-off is counted down here, one cycle at a
    // time, while the sender keeps offering requests; otherwise the receiver
    // stalls at random unless a steady stretch is in force.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (rx_steady) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 14);
            end
        end
    end

    function automatic int clamp_coord(input int v);
        if (v < COORD_LO)
            return COORD_LO;
        if (v > COORD_HI)
            return COORD_HI;
        return v;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, (1 << COORD_BITS) - 1)) + COORD_LO;
    endfunction

    function automatic int rand_color();
        // Now and then the unused upper data bits are set too; only the low byte counts.
        if ($urandom_range(9) < 8)
            return $urandom_range(0, 255);
        return $urandom_range(0, (1 << CFG_DATA_BITS) - 1);
    endfunction

    // Offer one request and wait for it to be taken. Valid is never lowered at
    // the end, so back-to-back requests keep it high without a glitch; a random
    // gap lowers it before the next request instead.
    task automatic send_request(input logic act, input int x0, input int y0,
                                input int x1, input int y1);
        if (!tx_steady && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {COORD_BITS'(y1), COORD_BITS'(x1), COORD_BITS'(y0), COORD_BITS'(x0)};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic start_line(input int x0, input int y0, input int x1, input int y1);
        int dx;
        int dy;
        dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
        dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
        send_request(ACT_START, x0, y0, x1, y1);
        starts++;
        useful++;
        line_left = (dx > dy) ? dx : dy;
    endtask

    // Endpoint fields carry random bits on a step; the block must ignore them.
    task automatic step_line();
        send_request(ACT_STEP, rand_coord(), rand_coord(), rand_coord(), rand_coord());
        steps++;
        if (line_left > 0) begin
            line_left--;
            useful++;
        end
    endtask

    // Start a line and walk it: extra steps past the end are dropped by the
    // block, and the cap cuts the walk short so the next start abandons it.
    task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
                             input int extra, input int cap);
        int n;
        start_line(x0, y0, x1, y1);
        n = line_left + extra;
        if (n > cap)
            n = cap;
        repeat (n) step_line();
    endtask

    // Stop offering requests until every pixel is back, then let any trailing
    // step with no result leave the two pipeline registers.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_BITS'(value);
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // An image size of 8192 fits the register and covers every nonnegative
    // coordinate, so only pixels with a negative coordinate fall outside.
    task automatic configure(input int w, input int h, input int r, input int g, input int b);
        drain();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_COLOR_RED, r);
        write_reg(REG_COLOR_GREEN, g);
        write_reg(REG_COLOR_BLUE, b);
        i_cfg_valid <= 1'b0;
        img_w = w % (1 << DIM_BITS);
        img_h = h % (1 << DIM_BITS);
        settings++;
    endtask

    // Most lines are short and sit around the image edges so the bounds flag
    // flips along them; some start anywhere in the coordinate range, and a few
    // join two random points and are abandoned partway.
    task automatic random_line();
        int kind;
        int span_x;
        int span_y;
        int x0;
        int y0;
        int x1;
        int y1;
        int extra;
        int cap;
        int r;
        kind   = $urandom_range(99);
        extra  = 0;
        cap    = NO_CAP;
        span_x = ((img_w > 1024) ? 1024 : img_w) + 40;
        span_y = ((img_h > 1024) ? 1024 : img_h) + 40;
        if (kind < 80) begin
            if (kind < 55) begin
                x0 = int'($urandom_range(0, span_x)) - 20;
                y0 = int'($urandom_range(0, span_y)) - 20;
            end else begin
                x0 = rand_coord();
                y0 = rand_coord();
            end
            x1 = clamp_coord(x0 + int'($urandom_range(0, 30)) - 15);
            y1 = clamp_coord(y0 + int'($urandom_range(0, 30)) - 15);
            if ($urandom_range(19) == 0) begin
                x1 = x0;
                y1 = y0;
            end
            r = $urandom_range(9);
            if (r == 0)
                extra = $urandom_range(1, 2);
            else if (r == 1)
                cap = $urandom_range(0, 8);
        end else begin
            x0  = rand_coord();
            y0  = rand_coord();
            x1  = rand_coord();
            y1  = rand_coord();
            cap = $urandom_range(0, 30);
        end
        draw_line(x0, y0, x1, y1, extra, cap);
        // Occasional stray step, often with no line in progress.
        if ($urandom_range(19) == 0)
            step_line();
    endtask

    // The receiver holds off while the sender streams steps of a long line, so
    // both pipeline registers fill and the input stalls.
    task automatic press_input();
        start_line(-8000, 100, 8000, 3100);
        hold_cycles = 80;
        tx_steady   = 1'b1;
        repeat (30) step_line();
        tx_steady   = 1'b0;
    endtask

    initial begin
        int phase;
        i_rst_n     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= ACT_START;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_data  <= '0;
        hold_cycles = 0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        starts      = 0;
        steps       = 0;
        useful      = 0;
        settings    = 0;
        line_left   = 0;
        img_w       = 640;
        img_h       = 480;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset configuration.
        step_line();                                      // nothing drawn yet: dropped
        start_line(0, 0, 0, 0);                           // equal endpoints: one last pixel
        step_line();                                      // line already over: dropped
        draw_line(COORD_LO, COORD_LO, COORD_HI, COORD_HI, 0, 2);   // full range, equal deltas
        draw_line(COORD_HI, COORD_LO, COORD_LO, COORD_HI, 0, 1);   // restart mid-line
        draw_line(0, 0, 2, 5, 1, NO_CAP);                 // steep, walked past its end
        draw_line(5, 3, 1, 0, 0, NO_CAP);                 // both directions negative
        draw_line(639, 479, 640, 480, 0, NO_CAP);         // last in-bounds pixel, then out
        draw_line(-1, 0, 0, -1, 0, NO_CAP);               // crossing the origin

        // Random part: one register setting per phase, extremes first. The
        // third phase carries the receiver hold-off and the fourth runs with
        // no idling on either side.
        phase = 0;
        while (useful < ITEM_GOAL) begin
            case (phase)
                0: begin
                    configure(1, 1, 255, 255, 255);
                end
                1: begin
                    configure(8192, 8192, 0, 0, 0);
                end
                2: begin
                    configure(8191, 8191, rand_color(), rand_color(), rand_color());
                end
                default: begin
                    configure($urandom_range(1, 8192), $urandom_range(1, 8192),
                              rand_color(), rand_color(), rand_color());
                end
            endcase
            tx_steady = (phase == 3);
            rx_steady = (phase == 3);
            if (phase == 2)
                press_input();
            repeat (10) random_line();
            tx_steady = 1'b0;
            rx_steady = 1'b0;
            phase++;
        end

        // Wait for the last pixels, then give the pipeline time to show any extra one.
        drain();
        $display("summary: %0d line starts and %0d steps sent, %0d pixels compared",
                 starts, steps, checked);
        $display("summary: %0d register settings, image sizes from one to full, colors 0 to 255",
                 settings);
        if (errors == 0 && pending == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
